FILE: sv/gebl_pkg.sv
// ----------------------------------------------------------------------------
// gebl_pkg
// Shared constants, codes and types of the grid elevation bilinear lookup.
// ----------------------------------------------------------------------------
package gebl_pkg;

	// default build of the tile
	localparam int GRID_SIDE_DEF      = 1201;
	localparam int SEC_PER_SAMPLE_DEF = 3;
	localparam int FRAC_BITS_DEF      = 8;

	// field widths
	localparam int CMD_W     = 1;
	localparam int INDEX_W   = 21;
	localparam int SAMPLE_W  = 16;
	localparam int LAT_W     = 28;
	localparam int LON_W     = 29;
	localparam int ELEV_W    = 24;
	localparam int TLAT_W    = 8;
	localparam int TLON_W    = 9;
	localparam int CFG_W     = 9;
	localparam int IN_DATA_W = 96;

	// one tile spans one degree: 3600 arc-seconds, 8 fraction bits
	localparam int TILE_SPAN = 60 * 60 * 256;
	localparam int OFF_W     = 30;  // signed offset from the tile edge
	localparam int SPAN_W    = 20;  // offset once known to be inside the tile
	localparam int IDX_W     = 12;  // sample index along one axis (below 3600)
	localparam int REM_W     = 10;  // offset within one sample step (below 768)
	localparam int RECIP_SH  = 17;  // shift of the reciprocal used for / step

	localparam int Q_DEPTH   = 4;   // item queue between front and back
	localparam int OUT_DEPTH = 4;   // result queue

	typedef enum logic [0:0] {
		REG_TILE_LAT = 1'b0,
		REG_TILE_LON = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ITEM_LOAD  = 2'd0,  // write one sample
		ITEM_QUERY = 2'd1,  // four reads and a blend
		ITEM_MISS  = 2'd2,  // query outside the tile or grid, zero result
		ITEM_DROP  = 2'd3   // load beyond the grid, no effect
	} item_kind_t;

	typedef enum logic [0:0] {
		BK_IDLE = 1'b0,
		BK_READ = 1'b1
	} back_state_t;

endpackage

FILE: sv/gebl_ram.sv
// ----------------------------------------------------------------------------
// gebl_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gebl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/gebl_fifo.sv
// ----------------------------------------------------------------------------
// gebl_fifo
// Small flop-based queue with full and empty flags.
// ----------------------------------------------------------------------------
module gebl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [PW:0]   FULL_CNT = (PW + 1)'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      cnt_q;

	assign full  = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

FILE: sv/gebl_front.sv
// ----------------------------------------------------------------------------
// gebl_front
// Four-stage front end: tile offsets, range check and sample index, step
// remainder, fractions and grid address. Classifies each beat for the back.
// ----------------------------------------------------------------------------
module gebl_front #(
	parameter int GRID_SIDE      = gebl_pkg::GRID_SIDE_DEF,
	parameter int SEC_PER_SAMPLE = gebl_pkg::SEC_PER_SAMPLE_DEF,
	parameter int FRAC_BITS      = gebl_pkg::FRAC_BITS_DEF,
	parameter int AW             = $clog2(GRID_SIDE * GRID_SIDE)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  gebl_pkg::cmd_t                       in_cmd,
	input  logic        [gebl_pkg::INDEX_W-1:0]  in_index,
	input  logic signed [gebl_pkg::SAMPLE_W-1:0] in_value,
	input  logic signed [gebl_pkg::LAT_W-1:0]    in_lat,
	input  logic signed [gebl_pkg::LON_W-1:0]    in_lon,
	input  logic signed [gebl_pkg::TLAT_W-1:0]   tile_lat,
	input  logic signed [gebl_pkg::TLON_W-1:0]   tile_lon,
	output logic                                 q_push,
	input  logic                                 q_full,
	output gebl_pkg::item_kind_t                 q_kind,
	output logic        [AW-1:0]                 q_addr,
	output logic        [gebl_pkg::SAMPLE_W-1:0] q_value,
	output logic        [FRAC_BITS-1:0]          q_fy,
	output logic        [FRAC_BITS-1:0]          q_fx
);
	import gebl_pkg::*;

	localparam int STEP   = SEC_PER_SAMPLE * 256;
	localparam int RECIP  = ((1 << RECIP_SH) + SEC_PER_SAMPLE - 1) / SEC_PER_SAMPLE;
	localparam int RCP_W  = RECIP_SH + 1;
	localparam int VW     = FRAC_BITS + 2;  // (rem << FRAC_BITS) >> 8 stays below 3 << FRAC_BITS
	localparam int QPW    = IDX_W + RCP_W;
	localparam int FPW    = VW + RCP_W;
	localparam logic [31:0]             DEPTH_U  = 32'(GRID_SIDE * GRID_SIDE);
	localparam logic signed [OFF_W-1:0] SPAN_S   = OFF_W'(TILE_SPAN);
	localparam logic [RCP_W-1:0]        RCP      = RCP_W'(RECIP);
	localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(GRID_SIDE - 1);
	localparam logic [IDX_W-1:0]        ROW_TOP  = IDX_W'(GRID_SIDE - 2);

	logic en1, en2, en3, en4;

	// stage 1: offsets from the tile's south-west corner
	logic                       v_s1;
	cmd_t                       cmd_s1;
	logic [INDEX_W-1:0]         idx_s1;
	logic [SAMPLE_W-1:0]        val_s1;
	logic signed [OFF_W-1:0]    oy_s1, ox_s1;
	logic signed [OFF_W-1:0]    oy_c, ox_c;

	// stage 2: inside check, sample index
	logic                       v_s2;
	cmd_t                       cmd_s2;
	logic                       ldok_s2;
	logic [INDEX_W-1:0]         idx_s2;
	logic [SAMPLE_W-1:0]        val_s2;
	logic                       in_s2;
	logic [SPAN_W-1:0]          offy_s2, offx_s2;
	logic [IDX_W-1:0]           qy_s2, qx_s2;
	logic [QPW-1:0]             prody_c, prodx_c;

	// stage 3: remainder within the step, neighbor check
	logic                       v_s3;
	cmd_t                       cmd_s3;
	logic                       ldok_s3;
	logic [INDEX_W-1:0]         idx_s3;
	logic [SAMPLE_W-1:0]        val_s3;
	logic                       ok_s3;
	logic [REM_W-1:0]           remy_s3, remx_s3;
	logic [IDX_W-1:0]           rowm1_s3, qx_s3;
	logic [SPAN_W-1:0]          suby_c, subx_c;

	// stage 4: fractions and address, waiting for the queue
	logic                       v_s4;
	item_kind_t                 kind_s4;
	logic [AW-1:0]              addr_s4;
	logic [SAMPLE_W-1:0]        val_s4;
	logic [FRAC_BITS-1:0]       fy_s4, fx_s4;
	logic [REM_W+FRAC_BITS-1:0] scy_c, scx_c;
	logic [FPW-1:0]             fprody_c, fprodx_c;
	item_kind_t                 kind_c;
	logic [AW-1:0]              addr_c;

	assign en4      = !v_s4 || (kind_s4 == ITEM_DROP) || !q_full;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	assign q_push  = v_s4 && (kind_s4 != ITEM_DROP) && !q_full;
	assign q_kind  = kind_s4;
	assign q_addr  = addr_s4;
	assign q_value = val_s4;
	assign q_fy    = fy_s4;
	assign q_fx    = fx_s4;

	always_comb begin
		oy_c = OFF_W'(in_lat) - OFF_W'(tile_lat) * SPAN_S;
		ox_c = OFF_W'(in_lon) - OFF_W'(tile_lon) * SPAN_S;
	end

	// index = (offset >> 8) / seconds per sample, by reciprocal
	always_comb begin
		prody_c = QPW'(oy_s1[SPAN_W-1:8]) * QPW'(RCP);
		prodx_c = QPW'(ox_s1[SPAN_W-1:8]) * QPW'(RCP);
	end

	always_comb begin
		suby_c = offy_s2 - SPAN_W'(qy_s2) * SPAN_W'(STEP);
		subx_c = offx_s2 - SPAN_W'(qx_s2) * SPAN_W'(STEP);
	end

	always_comb begin
		scy_c    = {remy_s3, {FRAC_BITS{1'b0}}};
		scx_c    = {remx_s3, {FRAC_BITS{1'b0}}};
		fprody_c = FPW'(VW'(scy_c >> 8)) * FPW'(RCP);
		fprodx_c = FPW'(VW'(scx_c >> 8)) * FPW'(RCP);
		if (cmd_s3 == CMD_LOAD) begin
			kind_c = ldok_s3 ? ITEM_LOAD : ITEM_DROP;
			addr_c = AW'(idx_s3);
		end else begin
			kind_c = ok_s3 ? ITEM_QUERY : ITEM_MISS;
			// top-left neighbor; row index counts from the north
			addr_c = AW'(rowm1_s3) * AW'(GRID_SIDE) + AW'(qx_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			cmd_s1 <= in_cmd;
			idx_s1 <= in_index;
			val_s1 <= in_value;
			oy_s1  <= oy_c;
			ox_s1  <= ox_c;
		end
		if (en2) begin
			cmd_s2  <= cmd_s1;
			ldok_s2 <= (32'(idx_s1) < DEPTH_U);
			idx_s2  <= idx_s1;
			val_s2  <= val_s1;
			in_s2   <= !oy_s1[OFF_W-1] && (oy_s1 < SPAN_S) &&
			           !ox_s1[OFF_W-1] && (ox_s1 < SPAN_S);
			offy_s2 <= oy_s1[SPAN_W-1:0];
			offx_s2 <= ox_s1[SPAN_W-1:0];
			qy_s2   <= prody_c[RECIP_SH +: IDX_W];
			qx_s2   <= prodx_c[RECIP_SH +: IDX_W];
		end
		if (en3) begin
			cmd_s3   <= cmd_s2;
			ldok_s3  <= ldok_s2;
			idx_s3   <= idx_s2;
			val_s3   <= val_s2;
			ok_s3    <= in_s2 && (qy_s2 < LAST_IDX) && (qx_s2 < LAST_IDX);
			remy_s3  <= suby_c[REM_W-1:0];
			remx_s3  <= subx_c[REM_W-1:0];
			rowm1_s3 <= ROW_TOP - qy_s2;
			qx_s3    <= qx_s2;
		end
		if (en4) begin
			kind_s4 <= kind_c;
			addr_s4 <= addr_c;
			val_s4  <= val_s3;
			fy_s4   <= fprody_c[RECIP_SH +: FRAC_BITS];
			fx_s4   <= fprodx_c[RECIP_SH +: FRAC_BITS];
		end
	end

endmodule

FILE: sv/gebl_back.sv
// ----------------------------------------------------------------------------
// gebl_back
// Back end: grid RAM, read sequencer (four reads per query), blend pipeline
// and result queue. A query starts only when the result queue has a free slot.
// ----------------------------------------------------------------------------
module gebl_back #(
	parameter int GRID_SIDE = gebl_pkg::GRID_SIDE_DEF,
	parameter int FRAC_BITS = gebl_pkg::FRAC_BITS_DEF,
	parameter int AW        = $clog2(GRID_SIDE * GRID_SIDE)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_empty,
	output logic                               q_pop,
	input  gebl_pkg::item_kind_t               q_kind,
	input  logic [AW-1:0]                      q_addr,
	input  logic [gebl_pkg::SAMPLE_W-1:0]      q_value,
	input  logic [FRAC_BITS-1:0]               q_fy,
	input  logic [FRAC_BITS-1:0]               q_fx,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [gebl_pkg::ELEV_W-1:0]        out_elev,
	output logic                               out_in_tile
);
	import gebl_pkg::*;

	localparam int DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int RW    = SAMPLE_W + FRAC_BITS + 1;   // one row blended
	localparam int TW    = SAMPLE_W + 2 * FRAC_BITS + 1;
	localparam int SH    = 2 * FRAC_BITS - 8;
	localparam int RSV_W = $clog2(OUT_DEPTH + 1);
	localparam logic [FRAC_BITS:0] ONE      = (FRAC_BITS + 1)'(1 << FRAC_BITS);
	localparam logic [AW-1:0]      OFS_SIDE = AW'(GRID_SIDE);
	localparam logic [RSV_W-1:0]   RSV_MAX  = RSV_W'(OUT_DEPTH);

	back_state_t         state_q, state_d;
	logic [1:0]          ph_q;
	logic [AW-1:0]       base_q;
	logic [FRAC_BITS-1:0] fy_q, fx_q;
	logic [RSV_W-1:0]    rsv_q;

	logic                credit_ok, start, issue, issue_last, issue_miss;
	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [SAMPLE_W-1:0] ram_rdata;

	// read tag, lines up with the RAM read data
	logic                 tg_v_s1, tg_last_s1, tg_miss_s1;
	logic [FRAC_BITS-1:0] fy_s1, fx_s1;
	logic [SAMPLE_W-1:0]  h_sh_q [3];

	logic                        v_s2, miss_s2;
	logic signed [SAMPLE_W-1:0]  h0_s2, h1_s2, h2_s2, h3_s2;
	logic [FRAC_BITS-1:0]        fy_s2, fx_s2;

	logic                        v_s3, miss_s3;
	logic signed [RW-1:0]        rt_s3, rb_s3;
	logic [FRAC_BITS-1:0]        fy_s3;

	logic [FRAC_BITS:0]          wx0_c, wy0_c;
	logic signed [RW-1:0]        rt_c, rb_c;
	logic signed [TW-1:0]        t_c;
	logic [ELEV_W-1:0]           elev_c;
	logic                        of_full, of_empty, out_beat;
	logic [ELEV_W:0]             of_rdata;

	gebl_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (q_addr),
		.wdata (q_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign credit_ok = (rsv_q < RSV_MAX);

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = q_addr;
		start      = 1'b0;
		issue      = 1'b0;
		issue_last = 1'b0;
		issue_miss = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					case (q_kind)
						ITEM_LOAD: begin
							ram_we = 1'b1;
							q_pop  = 1'b1;
						end
						ITEM_MISS: begin
							if (credit_ok) begin
								q_pop      = 1'b1;
								start      = 1'b1;
								issue      = 1'b1;
								issue_last = 1'b1;
								issue_miss = 1'b1;
							end
						end
						ITEM_QUERY: begin
							if (credit_ok) begin
								q_pop   = 1'b1;
								start   = 1'b1;
								issue   = 1'b1;
								ram_re  = 1'b1;
								state_d = BK_READ;
							end
						end
						default: begin
							q_pop = 1'b1;
						end
					endcase
				end
			end
			BK_READ: begin
				ram_re = 1'b1;
				issue  = 1'b1;
				case (ph_q)
					2'd1:    ram_raddr = base_q + 1'b1;
					2'd2:    ram_raddr = base_q + OFS_SIDE;
					default: ram_raddr = base_q + OFS_SIDE + 1'b1;
				endcase
				if (ph_q == 2'd3) begin
					issue_last = 1'b1;
					state_d    = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			ph_q    <= '0;
			rsv_q   <= '0;
			tg_v_s1 <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start && !issue_miss) begin
				ph_q <= 2'd1;
			end else if (state_q == BK_READ) begin
				ph_q <= ph_q + 1'b1;
			end
			if (start && !out_beat) begin
				rsv_q <= rsv_q + 1'b1;
			end else if (out_beat && !start) begin
				rsv_q <= rsv_q - 1'b1;
			end
			tg_v_s1 <= issue;
			v_s2    <= tg_v_s1 && tg_last_s1;
			v_s3    <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			base_q <= q_addr;
			fy_q   <= q_fy;
			fx_q   <= q_fx;
		end
		tg_last_s1 <= issue_last;
		tg_miss_s1 <= issue_miss;
		fy_s1      <= fy_q;
		fx_s1      <= fx_q;
		if (tg_v_s1 && !tg_miss_s1) begin
			h_sh_q[2] <= h_sh_q[1];
			h_sh_q[1] <= h_sh_q[0];
			h_sh_q[0] <= ram_rdata;
		end
		// read order: north-west, north-east, south-west, south-east
		miss_s2 <= tg_miss_s1;
		h0_s2   <= h_sh_q[2];
		h1_s2   <= h_sh_q[1];
		h2_s2   <= h_sh_q[0];
		h3_s2   <= ram_rdata;
		fy_s2   <= fy_s1;
		fx_s2   <= fx_s1;
		miss_s3 <= miss_s2;
		rt_s3   <= rt_c;
		rb_s3   <= rb_c;
		fy_s3   <= fy_s2;
	end

	// weights are unsigned; a zero fraction gives a full weight of 1 << FRAC_BITS
	always_comb begin
		wx0_c = ONE - (FRAC_BITS + 1)'(fx_s2);
		wy0_c = ONE - (FRAC_BITS + 1)'(fy_s3);
		rt_c  = RW'(h0_s2) * RW'($signed({1'b0, wx0_c}))
		      + RW'(h1_s2) * RW'($signed({1'b0, fx_s2}));
		rb_c  = RW'(h2_s2) * RW'($signed({1'b0, wx0_c}))
		      + RW'(h3_s2) * RW'($signed({1'b0, fx_s2}));
		t_c   = TW'(rt_s3) * TW'($signed({1'b0, fy_s3}))
		      + TW'(rb_s3) * TW'($signed({1'b0, wy0_c}));
		// arithmetic shift floors toward minus infinity
		elev_c = ELEV_W'(t_c >>> SH);
	end

	assign out_beat = out_valid && out_ready;

	gebl_fifo #(
		.WIDTH (ELEV_W + 1),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (v_s3),
		.wdata  ({!miss_s3, (miss_s3 ? {ELEV_W{1'b0}} : elev_c)}),
		.full   (of_full),
		.pop    (out_beat),
		.rdata  (of_rdata),
		.empty  (of_empty)
	);

	// slot reserved at query start, so the queue is never full on a push
	assign out_valid   = !of_empty || (of_full && 1'b0);
	assign out_elev    = of_rdata[ELEV_W-1:0];
	assign out_in_tile = of_rdata[ELEV_W];

endmodule

FILE: sv/grid_elevation_bilinear_lookup.sv
// ----------------------------------------------------------------------------
// grid_elevation_bilinear_lookup
// Holds one square tile of 16-bit elevation samples and answers bilinear
// queries in metres times 256. Load beats (tuser = 0) write one sample each at
// one beat per cycle while nothing stalls and give no result; the grid RAM has
// no reset, and a query must only touch samples already loaded. Query beats
// (tuser = 1) give one result each, in order, with tuser = in_tile; a query
// outside the tile, or whose east or north neighbor falls off the grid, returns
// in_tile = 0 and zero. The front end takes a beat every cycle unless the item
// queue is full. The back end writes once per load, reads four times per query
// (grid RAM has one read port) and takes no new item while those reads run.
// tile_lat and tile_lon are written on the cfg channel, which is always ready;
// the user must do so only while no beat is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module grid_elevation_bilinear_lookup #(
	parameter int GRID_SIDE      = gebl_pkg::GRID_SIDE_DEF,
	parameter int SEC_PER_SAMPLE = gebl_pkg::SEC_PER_SAMPLE_DEF,
	parameter int FRAC_BITS      = gebl_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// sample_index[20:0], sample_value[36:21], lat_pos[64:37], lon_pos[93:65]
	input  logic [gebl_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// cmd[0]
	input  logic [gebl_pkg::CMD_W-1:0]         s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// elevation[23:0]
	output logic [gebl_pkg::ELEV_W-1:0]        m_axis_tdata,
	// in_tile[0]
	output logic                               m_axis_tuser,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [0:0]                         cfg_addr,
	input  logic [gebl_pkg::CFG_W-1:0]         cfg_data
);
	import gebl_pkg::*;

	localparam int AW = $clog2(GRID_SIDE * GRID_SIDE);
	localparam int QW = 2 + AW + SAMPLE_W + 2 * FRAC_BITS;

	logic signed [TLAT_W-1:0] tile_lat_q;
	logic signed [TLON_W-1:0] tile_lon_q;

	logic                  f_push, q_full, q_empty, q_pop;
	item_kind_t            f_kind, b_kind;
	logic [AW-1:0]         f_addr, b_addr;
	logic [SAMPLE_W-1:0]   f_value, b_value;
	logic [FRAC_BITS-1:0]  f_fy, f_fx, b_fy, b_fx;
	logic [1:0]            b_kind_raw;
	logic [QW-1:0]         q_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_lat_q <= '0;
			tile_lon_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_addr))
				REG_TILE_LAT: tile_lat_q <= cfg_data[TLAT_W-1:0];
				REG_TILE_LON: tile_lon_q <= cfg_data[TLON_W-1:0];
				default: ;
			endcase
		end
	end

	gebl_front #(
		.GRID_SIDE      (GRID_SIDE),
		.SEC_PER_SAMPLE (SEC_PER_SAMPLE),
		.FRAC_BITS      (FRAC_BITS),
		.AW             (AW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (cmd_t'(s_axis_tuser)),
		.in_index (s_axis_tdata[20:0]),
		.in_value (s_axis_tdata[36:21]),
		.in_lat   (s_axis_tdata[64:37]),
		.in_lon   (s_axis_tdata[93:65]),
		.tile_lat (tile_lat_q),
		.tile_lon (tile_lon_q),
		.q_push   (f_push),
		.q_full   (q_full),
		.q_kind   (f_kind),
		.q_addr   (f_addr),
		.q_value  (f_value),
		.q_fy     (f_fy),
		.q_fx     (f_fx)
	);

	gebl_fifo #(
		.WIDTH (QW),
		.DEPTH (Q_DEPTH)
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  ({f_kind, f_addr, f_value, f_fy, f_fx}),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign {b_kind_raw, b_addr, b_value, b_fy, b_fx} = q_rdata;
	assign b_kind = item_kind_t'(b_kind_raw);

	gebl_back #(
		.GRID_SIDE (GRID_SIDE),
		.FRAC_BITS (FRAC_BITS),
		.AW        (AW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.q_kind      (b_kind),
		.q_addr      (b_addr),
		.q_value     (b_value),
		.q_fy        (b_fy),
		.q_fx        (b_fx),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_elev    (m_axis_tdata),
		.out_in_tile (m_axis_tuser)
	);

endmodule

FILE: sv/gebl_checker.sv
// ----------------------------------------------------------------------------
// gebl_checker
// Port-level checks of the elevation lookup, bound to the top level.
// ----------------------------------------------------------------------------
module gebl_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [gebl_pkg::CMD_W-1:0]     s_axis_tuser,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [gebl_pkg::ELEV_W-1:0]    m_axis_tdata,
	input logic                           m_axis_tuser,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [0:0]                     cfg_addr,
	input logic [gebl_pkg::CFG_W-1:0]     cfg_data
);
	import gebl_pkg::*;

	logic [5:0] pend_q;
	logic       query_beat, out_beat;

	assign query_beat = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_QUERY);
	assign out_beat   = m_axis_tvalid && m_axis_tready;

	// queries accepted and not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (query_beat && !out_beat) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_beat && !query_beat) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("out-of-tile result with nonzero elevation");

	a_result_has_query: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != '0)
		else $error("result beat without a pending query");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result beat changed");

	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready || ($stable(cfg_addr) && $stable(cfg_data)))
		else $error("cfg beat lost");

endmodule

bind grid_elevation_bilinear_lookup gebl_checker u_gebl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready),
	.cfg_addr      (cfg_addr),
	.cfg_data      (cfg_data)
);

FILE: bench/grid_elevation_bilinear_lookup_test.sv
// ----------------------------------------------------------------------------
// grid_elevation_bilinear_lookup_test
// Self-checking bench for the bilinear elevation lookup. Sample loads and
// queries go in on the input stream. A predictor keeps its own copy of the
// loaded samples and of the tile origin, and works out each query's answer.
// Queries only touch cells whose four corners are already loaded. Directed
// corner and off-tile cases come first. Then randomized traffic runs under
// several tile origins, the extremes among them, with bursty input and a
// stalling output side.
// ----------------------------------------------------------------------------
module grid_elevation_bilinear_lookup_test;
	timeunit 1ns;
	timeprecision 1ps;

	import gebl_pkg::*;

	localparam int GRID_SIDE     = GRID_SIDE_DEF;
	localparam int GRID_DEPTH    = GRID_SIDE * GRID_SIDE;
	localparam int STEP          = SEC_PER_SAMPLE_DEF * 256;
	localparam int FRAC_BITS     = FRAC_BITS_DEF;
	localparam int ONE           = 1 << FRAC_BITS;
	localparam int LAT_LIMIT     = 90 * TILE_SPAN;
	localparam int LON_LIMIT     = 180 * TILE_SPAN;
	localparam int SETTLE_CYCLES = 40;
	localparam int QUIET_LIMIT   = 4000;
	localparam int PHASE_BEATS   = 205;

	typedef struct packed {
		logic [ELEV_W-1:0] elevation;
		logic              in_tile;
	} tile_answer_t;

	typedef enum logic [1:0] {
		RX_STEADY,
		RX_RANDOM,
		RX_BURSTY
	} rx_pattern_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic [CMD_W-1:0]     s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [ELEV_W-1:0]    m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [0:0]           cfg_addr;
	logic [CFG_W-1:0]     cfg_data;

	// predictor state
	logic signed [TLAT_W-1:0] tile_lat_q = '0;
	logic signed [TLON_W-1:0] tile_lon_q = '0;
	shortint                  loaded_samples[int];
	tile_answer_t             answers_due[$];
	int                       ready_cells[$];
	bit                       cell_known[int];

	int          burst_left = 0;
	int          beats_sent = 0;
	int          mismatches = 0;
	rx_pattern_t rx_pattern = RX_RANDOM;
	int          rx_tick = 0;
	int          rx_hold = 0;

	grid_elevation_bilinear_lookup dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// row 0 of the file is the north edge; y counts cells up from the south
	function automatic int grid_index(input int y, input int x);
		return (GRID_SIDE - 1 - y) * GRID_SIDE + x;
	endfunction

	function automatic int sample_at(input int y, input int x);
		int idx;
		idx = grid_index(y, x);
		return loaded_samples.exists(idx) ? int'(loaded_samples[idx]) : 0;
	endfunction

	function automatic tile_answer_t blend_elevation(input logic signed [LAT_W-1:0] lat,
			input logic signed [LON_W-1:0] lon);
		tile_answer_t ans;
		longint       oy, ox, y, x, fy, fx, acc;
		ans = '0;
		oy = longint'(lat) - longint'(tile_lat_q) * TILE_SPAN;
		ox = longint'(lon) - longint'(tile_lon_q) * TILE_SPAN;
		if (oy < 0 || oy >= TILE_SPAN || ox < 0 || ox >= TILE_SPAN)
			return ans;
		y = oy / STEP;
		x = ox / STEP;
		if (y + 1 >= GRID_SIDE || x + 1 >= GRID_SIDE)
			return ans;
		fy = ((oy % STEP) << FRAC_BITS) / STEP;
		fx = ((ox % STEP) << FRAC_BITS) / STEP;
		acc = sample_at(y + 1, x) * fy * (ONE - fx)
			+ sample_at(y + 1, x + 1) * fy * fx
			+ sample_at(y, x) * (ONE - fy) * (ONE - fx)
			+ sample_at(y, x + 1) * (ONE - fy) * fx;
		// arithmetic shift floors toward minus infinity
		ans.elevation = ELEV_W'(acc >>> (2 * FRAC_BITS - 8));
		ans.in_tile = 1'b1;
		return ans;
	endfunction

	function automatic int rand_between(input int lo, input int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic int rand_sample();
		case ($urandom_range(0, 11))
		0: return -32768;
		1: return 32767;
		2: return 0;
		3: return -1;
		default: return rand_between(-32768, 32767);
		endcase
	endfunction

	function automatic int rand_frac();
		case ($urandom_range(0, 7))
		0: return 0;
		1: return STEP - 1;
		default: return rand_between(0, STEP - 1);
		endcase
	endfunction

	function automatic int rand_cell_coord();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? GRID_SIDE - 2 : 0;
		return rand_between(0, GRID_SIDE - 2);
	endfunction

	// a position a little beyond one edge of the tile, kept inside the field range
	function automatic int past_edge(input int base, input int limit);
		int below, above;
		below = base - 1 - int'($urandom_range(0, 3 * STEP));
		above = base + TILE_SPAN + int'($urandom_range(0, 3 * STEP));
		if (below < -limit || (above <= limit && $urandom_range(0, 1) == 1))
			return above;
		return below;
	endfunction

	// one input beat; the sender runs in bursts with random gaps between them
	task automatic send_beat(input cmd_t cmd, input int idx, input int val,
			input int lat, input int lon);
		logic [INDEX_W-1:0]  f_idx;
		logic [SAMPLE_W-1:0] f_val;
		logic [LAT_W-1:0]    f_lat;
		logic [LON_W-1:0]    f_lon;
		int                  gap;
		f_idx = INDEX_W'(idx);
		f_val = SAMPLE_W'(val);
		f_lat = LAT_W'(lat);
		f_lon = LON_W'(lon);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {{(IN_DATA_W - INDEX_W - SAMPLE_W - LAT_W - LON_W){1'b0}},
			f_lon, f_lat, f_val, f_idx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (cmd == CMD_LOAD) begin
			// loads past the grid are dropped by the block
			if (int'(f_idx) < GRID_DEPTH) begin
				loaded_samples[int'(f_idx)] = shortint'(f_val);
				beats_sent++;
			end
		end else begin
			answers_due.push_back(blend_elevation(f_lat, f_lon));
			beats_sent++;
		end
	endtask

	task automatic send_load(input int idx, input int val);
		send_beat(CMD_LOAD, idx, val, int'($urandom), int'($urandom));
	endtask

	task automatic send_query(input int lat, input int lon);
		send_beat(CMD_QUERY, int'($urandom), int'($urandom), lat, lon);
	endtask

	// loads whatever corners of the cell are missing, then queries inside it
	task automatic query_cell(input int y, input int x, input int ry, input int rx);
		int cell_id;
		for (int dy = 0; dy < 2; dy++)
			for (int dx = 0; dx < 2; dx++)
				if (!loaded_samples.exists(grid_index(y + dy, x + dx)))
					send_load(grid_index(y + dy, x + dx), rand_sample());
		cell_id = y * GRID_SIDE + x;
		if (!cell_known.exists(cell_id)) begin
			cell_known[cell_id] = 1'b1;
			ready_cells.push_back(cell_id);
		end
		send_query(int'(tile_lat_q) * TILE_SPAN + y * STEP + ry,
			int'(tile_lon_q) * TILE_SPAN + x * STEP + rx);
	endtask

	task automatic send_miss();
		int base_lat, base_lon, lat, lon;
		base_lat = int'(tile_lat_q) * TILE_SPAN;
		base_lon = int'(tile_lon_q) * TILE_SPAN;
		case ($urandom_range(0, 3))
		0: begin
			lat = rand_between(-LAT_LIMIT, LAT_LIMIT);
			do
				lon = rand_between(-LON_LIMIT, LON_LIMIT);
			while (lon >= base_lon && lon < base_lon + TILE_SPAN);
		end
		1: begin
			lon = rand_between(-LON_LIMIT, LON_LIMIT);
			do
				lat = rand_between(-LAT_LIMIT, LAT_LIMIT);
			while (lat >= base_lat && lat < base_lat + TILE_SPAN);
		end
		2: begin
			lat = past_edge(base_lat, LAT_LIMIT);
			lon = base_lon + rand_between(0, TILE_SPAN - 1);
		end
		default: begin
			lat = base_lat + rand_between(0, TILE_SPAN - 1);
			lon = past_edge(base_lon, LON_LIMIT);
		end
		endcase
		send_query(lat, lon);
	endtask

	// hold input until every answer is back, then let trailing loads finish
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_tile(input int lat_deg, input int lon_deg);
		quiesce();
		cfg_valid <= 1'b1;
		cfg_addr <= REG_TILE_LAT;
		cfg_data <= CFG_W'(lat_deg);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tile_lat_q = TLAT_W'(lat_deg);
		cfg_addr <= REG_TILE_LON;
		cfg_data <= CFG_W'(lon_deg);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tile_lon_q = TLON_W'(lon_deg);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random_traffic(input int beats);
		int target, halfway, sel, cell_id;
		bit paused;
		target = beats_sent + beats;
		halfway = beats_sent + beats / 2;
		paused = 1'b0;
		while (beats_sent < target) begin
			sel = $urandom_range(0, 99);
			if (sel < 40 && ready_cells.size() != 0) begin
				cell_id = ready_cells[$urandom_range(0, ready_cells.size() - 1)];
				query_cell(cell_id / GRID_SIDE, cell_id % GRID_SIDE, rand_frac(),
					rand_frac());
			end else if (sel < 62) begin
				query_cell(rand_cell_coord(), rand_cell_coord(), rand_frac(), rand_frac());
			end else if (sel < 77 && ready_cells.size() != 0) begin
				cell_id = ready_cells[$urandom_range(0, ready_cells.size() - 1)];
				send_load(grid_index(cell_id / GRID_SIDE + $urandom_range(0, 1),
					cell_id % GRID_SIDE + $urandom_range(0, 1)), rand_sample());
			end else if (sel < 89) begin
				send_miss();
			end else if (sel < 94) begin
				send_load(rand_between(GRID_DEPTH, (1 << INDEX_W) - 1), rand_sample());
			end else begin
				send_load(rand_between(0, GRID_DEPTH - 1), rand_sample());
			end
			if (!paused && beats_sent >= halfway) begin
				quiesce();
				paused = 1'b1;
			end
		end
	endtask

	// corner cells of the reset tile, full-scale samples, fraction extremes
	task automatic test_reset_tile_corners();
		send_load(grid_index(0, 0), 32767);
		send_load(grid_index(1, 0), 32767);
		send_load(grid_index(0, 1), -32768);
		send_load(grid_index(1, 1), -32768);
		query_cell(0, 0, 0, 0);
		query_cell(0, 0, STEP - 1, STEP - 1);
		query_cell(0, 0, STEP / 2, 129);
		// north-east cell reads the top row and the east column
		send_load(grid_index(GRID_SIDE - 2, GRID_SIDE - 2), -32768);
		send_load(grid_index(GRID_SIDE - 1, GRID_SIDE - 2), 1);
		send_load(grid_index(GRID_SIDE - 2, GRID_SIDE - 1), -1);
		send_load(grid_index(GRID_SIDE - 1, GRID_SIDE - 1), 32767);
		query_cell(GRID_SIDE - 2, GRID_SIDE - 2, 0, 0);
		query_cell(GRID_SIDE - 2, GRID_SIDE - 2, STEP - 1, 0);
		send_load(GRID_DEPTH - 1, 'h5A5A);
	endtask

	// just off each edge, far corners of the globe, loads past the grid
	task automatic test_outside_tile();
		int base_lat, base_lon;
		base_lat = int'(tile_lat_q) * TILE_SPAN;
		base_lon = int'(tile_lon_q) * TILE_SPAN;
		send_query(base_lat - 1, base_lon);
		send_query(base_lat + TILE_SPAN, base_lon);
		send_query(base_lat, base_lon - 1);
		send_query(base_lat, base_lon + TILE_SPAN);
		send_query(-LAT_LIMIT, LON_LIMIT);
		send_query(LAT_LIMIT, -LON_LIMIT);
		send_load(GRID_DEPTH, rand_sample());
		send_load((1 << INDEX_W) - 1, rand_sample());
	endtask

	task automatic test_tile_sweep();
		int lat_deg[5] = '{-90, 89, -90, 89, 0};
		int lon_deg[5] = '{-180, 179, 179, -180, 0};
		lat_deg[4] = rand_between(-90, 89);
		lon_deg[4] = rand_between(-180, 179);
		for (int i = 0; i < 5; i++) begin
			write_tile(lat_deg[i], lon_deg[i]);
			run_random_traffic(PHASE_BEATS);
		end
	endtask

	// output side cycles through steady, random and bursty stall behavior
	always @(posedge clk) begin
		rx_tick++;
		if (rx_tick % 700 == 0)
			rx_pattern = rx_pattern_t'((int'(rx_pattern) + 1) % 3);
		case (rx_pattern)
		RX_STEADY: m_axis_tready <= 1'b1;
		RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
		default: begin
			if (rx_hold == 0 && $urandom_range(0, 15) == 0)
				rx_hold = $urandom_range(4, 30);
			m_axis_tready <= (rx_hold == 0);
			if (rx_hold != 0)
				rx_hold--;
		end
		endcase
	end

	always @(posedge clk) begin : check_answers
		tile_answer_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (answers_due.size() == 0) begin
				mismatches++;
				$display("%0t: expected no beat, got elevation %0d in_tile %0b",
					$time, $signed(m_axis_tdata), m_axis_tuser);
			end else begin
				want = answers_due.pop_front();
				if (m_axis_tdata !== want.elevation) begin
					mismatches++;
					$display("%0t: elevation expected %0d got %0d", $time,
						$signed(want.elevation), $signed(m_axis_tdata));
				end
				if (m_axis_tuser !== want.in_tile) begin
					mismatches++;
					$display("%0t: in_tile expected %0b got %0b", $time,
						want.in_tile, m_axis_tuser);
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("grid_elevation_bilinear_lookup_test NOT OK");
		$finish;
	end

	initial begin
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= CMD_LOAD;
		m_axis_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_addr <= REG_TILE_LAT;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_tile_corners();
		test_outside_tile();
		test_tile_sweep();
		quiesce();
		if (mismatches == 0)
			$display("grid_elevation_bilinear_lookup_test OK");
		else
			$display("grid_elevation_bilinear_lookup_test NOT OK");
		$finish;
	end

endmodule

FILE: files.f
sv/gebl_pkg.sv
sv/gebl_ram.sv
sv/gebl_fifo.sv
sv/gebl_front.sv
sv/gebl_back.sv
sv/grid_elevation_bilinear_lookup.sv
sv/gebl_checker.sv
bench/grid_elevation_bilinear_lookup_test.sv
